// ----- rtl/nmea_rmc_sentence_parser_top_assert.svh -----
// assertion macros for the rmc sentence parser
`ifndef NMEA_RMC_SENTENCE_PARSER_TOP_ASSERT_SVH
`define NMEA_RMC_SENTENCE_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define NRMC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nrmc check failed");

// next-cycle implication
`define NRMC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nrmc check failed");

`endif

// ----- rtl/nrmc_pkg.sv -----
// shared types, constants and tables of the rmc sentence parser
package nrmc_pkg;

   localparam logic [19:0] SAT_INT = 20'd999999;
   localparam logic [19:0] SPEED_MAX = 20'd999999;
   localparam logic [16:0] COURSE_MAX = 17'd99999;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_A = 8'h41;
   localparam logic [7:0] CH_V = 8'h56;
   localparam logic [7:0] CH_N = 8'h4E;
   localparam logic [7:0] CH_S = 8'h53;
   localparam logic [7:0] CH_E = 8'h45;
   localparam logic [7:0] CH_W = 8'h57;

   localparam logic [3:0] FI_HUNT = 4'd0;
   localparam logic [3:0] FI_HEADER = 4'd1;
   localparam logic [3:0] FI_TIME = 4'd2;
   localparam logic [3:0] FI_STATUS = 4'd3;
   localparam logic [3:0] FI_LAT = 4'd4;
   localparam logic [3:0] FI_LAT_HEMI = 4'd5;
   localparam logic [3:0] FI_LON = 4'd6;
   localparam logic [3:0] FI_LON_HEMI = 4'd7;
   localparam logic [3:0] FI_SPEED = 4'd8;
   localparam logic [3:0] FI_COURSE = 4'd9;
   localparam logic [3:0] FI_DATE = 4'd10;
   localparam logic [3:0] FI_SKIP = 4'd11;

   localparam logic [3:0] DP_DONE = 4'd15;

   localparam logic [2:0] RC_ACTIVE = 3'd0;
   localparam logic [2:0] RC_BAD_STATUS = 3'd2;
   localparam logic [2:0] RC_BAD_LAT_HEMI = 3'd3;
   localparam logic [2:0] RC_BAD_LON_HEMI = 3'd4;
   localparam logic [2:0] RC_NO_TERM = 3'd5;

   localparam logic [1:0] HEMI_FIRST = 2'd1;
   localparam logic [1:0] HEMI_SECOND = 2'd2;

   typedef struct packed {
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [9:0]  millisecond;
      logic        void_fix;
      logic [29:0] lat;
      logic [1:0]  lat_hemi;
      logic [33:0] lon;
      logic [1:0]  lon_hemi;
      logic [19:0] speed;
      logic [16:0] course;
      logic [19:0] date;
   } fix_rec_type;

   typedef struct packed {
      logic [2:0]  header_match;
      logic [3:0]  field_index;
      logic [3:0]  digit_pos;
      logic [33:0] acc;
      logic [23:0] frac;
      logic [1:0]  frac_rem;
      logic [23:0] time_bcd;
      logic        time_sat;
      logic [2:0]  error_code;
      fix_rec_type pending;
      fix_rec_type held;
   } state_type;

   function automatic logic [7:0] header_char(input logic [2:0] idx);
      logic [7:0] r;
      unique case (idx)
         3'd1: r = 8'h47;
         3'd2: r = 8'h50;
         3'd3: r = 8'h52;
         3'd4: r = 8'h4D;
         3'd5: r = 8'h43;
         default: r = CH_DOLLAR;
      endcase
      return r;
   endfunction

   // degree digit weight in 1e-7 degree
   function automatic logic [33:0] deg_weight(input logic is_lon, input logic [1:0] p);
      logic [33:0] r;
      r = 34'd0;
      if (is_lon) begin
         unique case (p)
            2'd0: r = 34'd1000000000;
            2'd1: r = 34'd100000000;
            2'd2: r = 34'd10000000;
            default: r = 34'd0;
         endcase
      end else begin
         unique case (p)
            2'd0: r = 34'd100000000;
            2'd1: r = 34'd10000000;
            default: r = 34'd0;
         endcase
      end
      return r;
   endfunction

   // (50 * minute weight) / 3, every remainder being 2
   function automatic logic [20:0] min_quot(input logic [2:0] k);
      logic [20:0] r;
      unique case (k)
         3'd0: r = 21'd1666666;
         3'd1: r = 21'd166666;
         3'd2: r = 21'd16666;
         3'd3: r = 21'd1666;
         3'd4: r = 21'd166;
         3'd5: r = 21'd16;
         default: r = 21'd0;
      endcase
      return r;
   endfunction

   // {quotient, remainder} of 2*d by 3
   function automatic logic [4:0] twice_digit_div3(input logic [3:0] d);
      logic [4:0] r;
      unique case (d)
         4'd1: r = {3'd0, 2'd2};
         4'd2: r = {3'd1, 2'd1};
         4'd3: r = {3'd2, 2'd0};
         4'd4: r = {3'd2, 2'd2};
         4'd5: r = {3'd3, 2'd1};
         4'd6: r = {3'd4, 2'd0};
         4'd7: r = {3'd4, 2'd2};
         4'd8: r = {3'd5, 2'd1};
         4'd9: r = {3'd6, 2'd0};
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] frac_weight(input logic [3:0] fi, input logic [3:0] n);
      logic [6:0] r;
      r = 7'd0;
      if (fi == FI_TIME) begin
         unique case (n)
            4'd0: r = 7'd100;
            4'd1: r = 7'd10;
            4'd2: r = 7'd1;
            default: r = 7'd0;
         endcase
      end else if (fi == FI_SPEED || fi == FI_COURSE) begin
         unique case (n)
            4'd0: r = 7'd10;
            4'd1: r = 7'd1;
            default: r = 7'd0;
         endcase
      end
      return r;
   endfunction

endpackage

// ----- rtl/nrmc_step.sv -----
// next-state logic for one received byte
module nrmc_step (
   input  nrmc_pkg::state_type cur,
   input  logic [7:0]          character,
   output nrmc_pkg::state_type nxt,
   output logic                emit,
   output logic [2:0]          code
);
   import nrmc_pkg::*;

   fix_rec_type fin;
   logic        is_dig;
   logic [3:0]  dig;
   logic [26:0] cent_val;
   logic [23:0] num_acc;
   logic [3:0]  degn;
   logic        min_ok;
   logic [3:0]  min_k;
   logic [4:0]  dq;
   logic [2:0]  rem_sum;
   logic        rem_carry;
   logic [2:0]  err;
   logic [1:0]  hemi;

   assign is_dig = (character >= CH_ZERO) && (character <= CH_NINE);
   assign dig = is_dig ? character[3:0] : 4'd0;

   // field close
   always_comb begin
      fin = cur.pending;
      cent_val = 27'(cur.acc[19:0]) * 27'd100 + 27'(cur.frac);
      unique case (cur.field_index)
         FI_TIME: begin
            fin.hour = cur.time_sat ? 7'd99 :
               7'(cur.time_bcd[23:20]) * 7'd10 + 7'(cur.time_bcd[19:16]);
            fin.minute = cur.time_sat ? 7'd99 :
               7'(cur.time_bcd[15:12]) * 7'd10 + 7'(cur.time_bcd[11:8]);
            fin.second = cur.time_sat ? 7'd99 :
               7'(cur.time_bcd[7:4]) * 7'd10 + 7'(cur.time_bcd[3:0]);
            fin.millisecond = cur.frac[9:0];
         end
         FI_LAT: if (cur.digit_pos != 4'd0) fin.lat = 30'(cur.acc + 34'(cur.frac));
         FI_LON: if (cur.digit_pos != 4'd0) fin.lon = cur.acc + 34'(cur.frac);
         FI_SPEED: if (cur.digit_pos != 4'd0)
            fin.speed = (cent_val > 27'(SPEED_MAX)) ? SPEED_MAX : cent_val[19:0];
         FI_COURSE: if (cur.digit_pos != 4'd0)
            fin.course = (cent_val > 27'(COURSE_MAX)) ? COURSE_MAX : cent_val[16:0];
         FI_DATE: if (cur.digit_pos != 4'd0) fin.date = cur.acc[19:0];
         default: fin = cur.pending;
      endcase
   end

   // coordinate digit placement
   always_comb begin
      degn = (cur.field_index == FI_LAT) ? 4'd2 : 4'd3;
      min_ok = 1'b0;
      min_k = 4'd0;
      if (cur.digit_pos >= degn && cur.digit_pos < degn + 4'd2) begin
         min_ok = 1'b1;
         min_k = cur.digit_pos - degn;
      end else if (cur.digit_pos > degn + 4'd2 && cur.digit_pos < degn + 4'd7) begin
         min_ok = 1'b1;
         min_k = cur.digit_pos - degn - 4'd1;
      end
      dq = twice_digit_div3(dig);
      rem_sum = 3'(cur.frac_rem) + 3'(dq[1:0]);
      rem_carry = rem_sum >= 3'd3;
   end

   always_comb begin
      nxt = cur;
      emit = 1'b0;
      code = RC_ACTIVE;
      err = cur.error_code;
      hemi = 2'd0;
      num_acc = 24'(cur.acc[19:0]) * 24'd10 + 24'(dig);
      priority if (character == CH_DOLLAR) begin
         nxt.field_index = FI_HUNT;
         nxt.header_match = 3'd1;
         nxt.digit_pos = 4'd0;
         nxt.acc = '0;
         nxt.frac = '0;
         nxt.frac_rem = '0;
         nxt.time_bcd = '0;
         nxt.time_sat = 1'b0;
         if (cur.field_index != FI_HUNT) begin
            emit = 1'b1;
            code = RC_NO_TERM;
         end
      end else if (cur.field_index == FI_HUNT) begin
         if (cur.header_match >= 3'd1 && cur.header_match <= 3'd5 &&
             character == header_char(cur.header_match)) begin
            if (cur.header_match == 3'd5) begin
               nxt.header_match = 3'd0;
               nxt.field_index = FI_HEADER;
               nxt.error_code = 3'd0;
               nxt.digit_pos = 4'd0;
               nxt.acc = '0;
               nxt.frac = '0;
               nxt.frac_rem = '0;
               nxt.time_bcd = '0;
               nxt.time_sat = 1'b0;
               nxt.pending = cur.held;
            end else begin
               nxt.header_match = cur.header_match + 3'd1;
            end
         end else begin
            nxt.header_match = 3'd0;
         end
      end else if (character == CH_STAR) begin
         if (err == 3'd0 && (cur.field_index < FI_STATUS ||
             (cur.field_index == FI_STATUS && cur.digit_pos == 4'd0)))
            err = RC_BAD_STATUS;
         nxt.error_code = err;
         nxt.pending = fin;
         nxt.held = fin;
         nxt.field_index = FI_HUNT;
         nxt.header_match = 3'd0;
         nxt.digit_pos = 4'd0;
         nxt.acc = '0;
         nxt.frac = '0;
         nxt.frac_rem = '0;
         nxt.time_bcd = '0;
         nxt.time_sat = 1'b0;
         emit = 1'b1;
         code = (err != 3'd0) ? err : {2'd0, fin.void_fix};
      end else if (cur.field_index == FI_HEADER) begin
         if (character == CH_COMMA) nxt.field_index = FI_TIME;
      end else if (cur.field_index >= FI_SKIP) begin
         nxt.field_index = cur.field_index;
      end else if (cur.field_index == FI_STATUS && cur.digit_pos == 4'd0) begin
         if (character == CH_A || character == CH_V) begin
            nxt.pending.void_fix = (character == CH_V);
            nxt.digit_pos = 4'd1;
         end else begin
            nxt.error_code = RC_BAD_STATUS;
            nxt.field_index = FI_SKIP;
         end
      end else if ((cur.field_index == FI_LAT_HEMI || cur.field_index == FI_LON_HEMI) &&
                   cur.digit_pos == 4'd0 && character != CH_COMMA) begin
         if (cur.field_index == FI_LAT_HEMI)
            hemi = (character == CH_N) ? HEMI_FIRST : (character == CH_S) ? HEMI_SECOND : 2'd0;
         else
            hemi = (character == CH_E) ? HEMI_FIRST : (character == CH_W) ? HEMI_SECOND : 2'd0;
         if (hemi == 2'd0) begin
            nxt.error_code = (cur.field_index == FI_LAT_HEMI) ? RC_BAD_LAT_HEMI
                                                              : RC_BAD_LON_HEMI;
            nxt.field_index = FI_SKIP;
         end else begin
            if (cur.field_index == FI_LAT_HEMI) nxt.pending.lat_hemi = hemi;
            else nxt.pending.lon_hemi = hemi;
            nxt.digit_pos = 4'd1;
         end
      end else if (character == CH_COMMA) begin
         nxt.pending = fin;
         nxt.field_index = cur.field_index + 4'd1;
         nxt.digit_pos = 4'd0;
         nxt.acc = '0;
         nxt.frac = '0;
         nxt.frac_rem = '0;
         nxt.time_bcd = '0;
         nxt.time_sat = 1'b0;
      end else if (cur.field_index == FI_LAT || cur.field_index == FI_LON) begin
         if (cur.digit_pos < degn) begin
            nxt.acc = cur.acc + 34'(dig) *
               deg_weight(cur.field_index == FI_LON, cur.digit_pos[1:0]);
         end else if (min_ok) begin
            nxt.frac_rem = rem_carry ? 2'(rem_sum - 3'd3) : rem_sum[1:0];
            nxt.frac = cur.frac + 24'(dig) * 24'(min_quot(min_k[2:0])) +
               24'(dq[4:2]) + 24'(rem_carry);
         end
         if (cur.digit_pos < DP_DONE) nxt.digit_pos = cur.digit_pos + 4'd1;
      end else if (cur.field_index == FI_TIME || cur.field_index == FI_SPEED ||
                   cur.field_index == FI_COURSE || cur.field_index == FI_DATE) begin
         if (cur.digit_pos != DP_DONE) begin
            if (is_dig) begin
               if (cur.digit_pos <= 4'd1) begin
                  nxt.acc = (num_acc > 24'(SAT_INT)) ? 34'(SAT_INT) : 34'(num_acc);
                  nxt.digit_pos = 4'd1;
                  if (cur.field_index == FI_TIME) begin
                     nxt.time_sat = cur.time_sat | (cur.time_bcd[23:20] != 4'd0);
                     nxt.time_bcd = {cur.time_bcd[19:0], dig};
                  end
               end else begin
                  nxt.frac = cur.frac + 24'(dig) *
                     24'(frac_weight(cur.field_index, cur.digit_pos - 4'd2));
                  if (cur.digit_pos < 4'd5) nxt.digit_pos = cur.digit_pos + 4'd1;
               end
            end else if (character == CH_DOT && cur.digit_pos <= 4'd1) begin
               nxt.digit_pos = 4'd2;
            end else begin
               nxt.digit_pos = DP_DONE;
            end
         end
      end else begin
         nxt.field_index = cur.field_index;
      end
   end

endmodule

// ----- rtl/nmea_rmc_sentence_parser_top.sv -----
// top level of the rmc sentence parser: state and response registers
// Usage: feed sentence bytes on req_character with req_valid; a byte is taken
// at a clock edge with req_valid high and req_stall low. Every byte is
// processed in the cycle it is taken: one byte per cycle while req_stall is low.
// A response (result code plus the committed fix fields) comes out on the
// rsp_ ports after '*', after a status or hemisphere error is closed by '*',
// or when a new '$' cuts an open sentence short. Most bytes give no response.
// The response is valid in the cycle after the closing byte is taken.
// The response register holds one result; while it is full and rsp_stall is
// high, req_stall is high and no byte is taken, else bytes keep flowing.
// Reset (synchronous, active high) clears the parser, the committed fields
// and the response valid flag.
module nmea_rmc_sentence_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_code,
   output logic [6:0]  rsp_hour,
   output logic [6:0]  rsp_minute,
   output logic [6:0]  rsp_second,
   output logic [9:0]  rsp_millisecond,
   output logic [29:0] rsp_latitude_e7,
   output logic [1:0]  rsp_latitude_hemisphere,
   output logic [33:0] rsp_longitude_e7,
   output logic [1:0]  rsp_longitude_hemisphere,
   output logic [19:0] rsp_speed_centi,
   output logic [16:0] rsp_course_centi,
   output logic [19:0] rsp_date_ddmmyy
);
   import nrmc_pkg::*;

   state_type   state_ff, state_in;
   logic        step_emit;
   logic [2:0]  step_code;
   logic        req_accept;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_code_ff, rsp_code_in;
   fix_rec_type rsp_fix_ff, rsp_fix_in;

   nrmc_step u_step (
      .cur       (state_ff),
      .character (req_character),
      .nxt       (state_in),
      .emit      (step_emit),
      .code      (step_code)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_code_in = rsp_code_ff;
      rsp_fix_in = rsp_fix_ff;
      if (req_accept && step_emit) begin
         rsp_valid_in = 1'b1;
         rsp_code_in = step_code;
         rsp_fix_in = state_in.held;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_code_ff <= rsp_code_in;
      rsp_fix_ff <= rsp_fix_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_hour = rsp_fix_ff.hour;
   assign rsp_minute = rsp_fix_ff.minute;
   assign rsp_second = rsp_fix_ff.second;
   assign rsp_millisecond = rsp_fix_ff.millisecond;
   assign rsp_latitude_e7 = rsp_fix_ff.lat;
   assign rsp_latitude_hemisphere = rsp_fix_ff.lat_hemi;
   assign rsp_longitude_e7 = rsp_fix_ff.lon;
   assign rsp_longitude_hemisphere = rsp_fix_ff.lon_hemi;
   assign rsp_speed_centi = rsp_fix_ff.speed;
   assign rsp_course_centi = rsp_fix_ff.course;
   assign rsp_date_ddmmyy = rsp_fix_ff.date;

`include "nmea_rmc_sentence_parser_top_assert.svh"

   `NRMC_ASSERT_NEXT(a_emit_loads_rsp, clock, reset, req_accept && step_emit, rsp_valid_ff)
   `NRMC_ASSERT_NOW(a_code_range, clock, reset, rsp_valid_ff, rsp_code_ff <= RC_NO_TERM)
   `NRMC_ASSERT_NOW(a_field_range, clock, reset, 1'b1, state_ff.field_index <= FI_SKIP)
   `NRMC_ASSERT_NOW(a_match_only_hunting, clock, reset, state_ff.header_match != 3'd0,
                    state_ff.field_index == FI_HUNT)

endmodule

// ----- tb/sv/tb_nmea_rmc_sentence_parser_top.sv -----
// self-checking testbench for the rmc sentence parser: byte stream in, fix responses checked
`timescale 1ns / 100ps
module tb_nmea_rmc_sentence_parser_top;
   import nrmc_pkg::*;

   typedef struct {
      logic [2:0]  code;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [9:0]  msec;
      logic [29:0] lat;
      logic [1:0]  lat_h;
      logic [33:0] lon;
      logic [1:0]  lon_h;
      logic [19:0] speed;
      logic [16:0] course;
      logic [19:0] date;
   } fix_result_type;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_result_code;
   logic [6:0]  rsp_hour, rsp_minute, rsp_second;
   logic [9:0]  rsp_millisecond;
   logic [29:0] rsp_latitude_e7;
   logic [1:0]  rsp_latitude_hemisphere;
   logic [33:0] rsp_longitude_e7;
   logic [1:0]  rsp_longitude_hemisphere;
   logic [19:0] rsp_speed_centi;
   logic [16:0] rsp_course_centi;
   logic [19:0] rsp_date_ddmmyy;

   nmea_rmc_sentence_parser_top u_dut (.*);

   always #5 clock = ~clock;

   logic [7:0]     byte_q[$];
   fix_result_type fix_q[$];
   int             errors = 0;
   int             cycles = 0;
   int             resp_count = 0;

   // parser shadow state
   int unsigned      hm, fi, dp, err;
   longint unsigned  acc, fr;
   logic [63:0]      pend[4], held[4];
   string            hdr = "$GPRMC";

   function automatic logic [63:0] getf(logic [63:0] w, int lo, int wd);
      return (w >> lo) & ((64'd1 << wd) - 1);
   endfunction

   function automatic logic [63:0] setf(logic [63:0] w, int lo, int wd, logic [63:0] v);
      logic [63:0] m;
      m = ((64'd1 << wd) - 1) << lo;
      return (w & ~m) | ((v << lo) & m);
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   task automatic clear_field();
      dp = 0; acc = 0; fr = 0;
   endtask

   task automatic push_fix(int unsigned code);
      fix_result_type r;
      r.code = code[2:0];
      r.hour = 7'(getf(held[0], 0, 7));
      r.minute = 7'(getf(held[0], 7, 7));
      r.second = 7'(getf(held[0], 14, 7));
      r.msec = 10'(getf(held[0], 21, 10));
      r.lat = 30'(getf(held[1], 0, 30));
      r.lat_h = 2'(getf(held[1], 30, 2));
      r.lon = 34'(getf(held[2], 0, 34));
      r.lon_h = 2'(getf(held[2], 34, 2));
      r.speed = 20'(getf(held[3], 0, 20));
      r.course = 17'(getf(held[3], 20, 17));
      r.date = 20'(getf(held[3], 37, 20));
      fix_q.push_back(r);
   endtask

   task automatic number_digit(logic [7:0] c, int unsigned fdig, int unsigned top_w);
      int unsigned n, wt;
      if (dp == 15) return;
      if (is_digit(c)) begin
         if (dp <= 1) begin
            acc = acc * 10 + (c - CH_ZERO);
            if (acc > 999999) acc = 999999;
            dp = 1;
         end else begin
            n = dp - 2;
            wt = top_w;
            repeat (n) wt = wt / 10;
            if (n < fdig) fr += (c - CH_ZERO) * wt;
            if (dp < 5) dp++;
         end
      end else if (c == CH_DOT && dp <= 1) begin
         dp = 2;
      end else begin
         dp = 15;
      end
   endtask

   task automatic coord_digit(logic [7:0] c, int unsigned degn);
      longint unsigned d, wt;
      int unsigned k;
      d = is_digit(c) ? c - CH_ZERO : 0;
      if (dp < degn) begin
         wt = 1;
         repeat (degn - 1 - dp) wt *= 10;
         acc += d * wt;
      end else if (dp < degn + 2 || (dp > degn + 2 && dp < degn + 7)) begin
         k = (dp < degn + 2) ? dp - degn : dp - degn - 1;
         wt = 1;
         repeat (5 - k) wt *= 10;
         fr += d * wt;
      end
      if (dp < 15) dp++;
   endtask

   task automatic close_field();
      longint unsigned v, lim;
      case (fi)
         FI_TIME: begin
            v = acc;
            pend[0] = setf(pend[0], 0, 7, v / 10000);
            pend[0] = setf(pend[0], 7, 7, (v % 10000) / 100);
            pend[0] = setf(pend[0], 14, 7, v % 100);
            pend[0] = setf(pend[0], 21, 10, fr);
         end
         FI_LAT, FI_LON: if (dp != 0) begin
            v = acc * 10000000 + (50 * fr) / 3;
            if (fi == FI_LAT) pend[1] = setf(pend[1], 0, 30, v);
            else pend[2] = setf(pend[2], 0, 34, v);
         end
         FI_SPEED, FI_COURSE: if (dp != 0) begin
            lim = (fi == FI_SPEED) ? 999999 : 99999;
            v = acc * 100 + fr;
            if (v > lim) v = lim;
            if (fi == FI_SPEED) pend[3] = setf(pend[3], 0, 20, v);
            else pend[3] = setf(pend[3], 20, 17, v);
         end
         FI_DATE: if (dp != 0) pend[3] = setf(pend[3], 37, 20, acc);
         default: ;
      endcase
   endtask

   task automatic predict_byte(logic [7:0] c);
      int unsigned code, h;
      bit was_open;
      if (c == CH_DOLLAR) begin
         was_open = fi != 0;
         fi = 0; hm = 1; clear_field();
         if (was_open) push_fix(RC_NO_TERM);
         return;
      end
      if (fi == FI_HUNT) begin
         if (hm >= 1 && hm <= 5 && c == hdr[hm]) begin
            hm++;
            if (hm == 6) begin
               hm = 0; fi = FI_HEADER; err = 0; clear_field();
               pend = held;
            end
         end else begin
            hm = 0;
         end
         return;
      end
      if (c == CH_STAR) begin
         if (fi >= FI_TIME && fi <= FI_DATE) close_field();
         if (err == 0 && (fi < FI_STATUS || (fi == FI_STATUS && dp == 0))) err = RC_BAD_STATUS;
         code = (err != 0) ? err : 32'(getf(pend[0], 31, 1));
         held = pend;
         fi = 0; hm = 0; clear_field();
         push_fix(code);
         return;
      end
      if (fi == FI_HEADER) begin
         if (c == CH_COMMA) begin
            fi = FI_TIME; clear_field();
         end
         return;
      end
      if (fi >= FI_SKIP) return;
      if (fi == FI_STATUS && dp == 0) begin
         if (c == CH_A || c == CH_V) begin
            pend[0] = setf(pend[0], 31, 1, 64'(c == CH_V));
            dp = 1;
         end else begin
            err = RC_BAD_STATUS; fi = FI_SKIP;
         end
         return;
      end
      if ((fi == FI_LAT_HEMI || fi == FI_LON_HEMI) && dp == 0 && c != CH_COMMA) begin
         if (fi == FI_LAT_HEMI)
            h = (c == CH_N) ? HEMI_FIRST : (c == CH_S) ? HEMI_SECOND : 0;
         else
            h = (c == CH_E) ? HEMI_FIRST : (c == CH_W) ? HEMI_SECOND : 0;
         if (h == 0) begin
            err = (fi == FI_LAT_HEMI) ? RC_BAD_LAT_HEMI : RC_BAD_LON_HEMI;
            fi = FI_SKIP;
         end else begin
            if (fi == FI_LAT_HEMI) pend[1] = setf(pend[1], 30, 2, 64'(h));
            else pend[2] = setf(pend[2], 34, 2, 64'(h));
            dp = 1;
         end
         return;
      end
      if (c == CH_COMMA) begin
         close_field();
         fi++;
         clear_field();
         return;
      end
      case (fi)
         FI_TIME: number_digit(c, 3, 100);
         FI_LAT: coord_digit(c, 2);
         FI_LON: coord_digit(c, 3);
         FI_SPEED, FI_COURSE: number_digit(c, 2, 10);
         FI_DATE: number_digit(c, 0, 1);
         default: ;
      endcase
   endtask

   // stimulus helpers
   task automatic put_str(string s);
      foreach (s[i]) byte_q.push_back(s[i]);
   endtask

   task automatic put_digits(int n);
      repeat (n) byte_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
   endtask

   task automatic put_any(int n);
      repeat (n) byte_q.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic put_number(int int_max, int frac_max);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return;
      if (sel == 1) begin
         put_str("99999999.999");
         return;
      end
      put_digits($urandom_range(0, int_max));
      if ($urandom_range(0, 3) != 0) begin
         put_str(".");
         put_digits($urandom_range(0, frac_max));
      end
      if (sel == 2) put_any($urandom_range(1, 3));
   endtask

   task automatic put_coord(int degn);
      int sel, n;
      sel = $urandom_range(0, 9);
      if (sel == 0) return;
      if (sel == 1) begin
         put_any($urandom_range(1, 12));
         return;
      end
      if (sel == 2) begin
         put_str(degn == 2 ? "9959.99999" : "99959.99999");
         return;
      end
      n = $urandom_range(0, degn + 8);
      for (int i = 0; i < n; i++) begin
         if (i == degn + 2) put_str(".");
         else put_digits(1);
      end
   endtask

   task automatic put_hemi(logic [7:0] a, logic [7:0] b);
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 8) byte_q.push_back(a);
      else if (sel < 16) byte_q.push_back(b);
      else if (sel < 18) ;
      else byte_q.push_back(8'($urandom_range(CH_A, 8'h5A)));
   endtask

   task automatic put_sentence();
      int sel, cut;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 99;
      put_str("$GPRMC");
      if ($urandom_range(0, 9) == 0) put_str("xyz");
      put_str(",");
      put_number(8, 5);
      if (cut == 1) return;
      put_str(",");
      sel = $urandom_range(0, 19);
      if (sel < 9) put_str("A");
      else if (sel < 18) put_str("V");
      else if (sel == 18) put_any(1);
      if (cut == 2) return;
      put_str(",");
      put_coord(2);
      if (cut == 3) return;
      put_str(",");
      put_hemi(CH_N, CH_S);
      if (cut == 4) return;
      put_str(",");
      put_coord(3);
      if (cut == 5) return;
      put_str(",");
      put_hemi(CH_E, CH_W);
      if (cut == 6) return;
      put_str(",");
      put_number(4, 3);
      if (cut == 7) return;
      put_str(",");
      put_number(4, 3);
      if (cut == 8) return;
      put_str(",");
      put_number(7, 2);
      if (cut == 9) return;
      if ($urandom_range(0, 1) != 0) put_str(",,,A");
      put_str("*4F\r\n");
   endtask

   task automatic check_field(string name, logic [63:0] expv, logic [63:0] act);
      if (expv !== act) begin
         errors++;
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, expv, act);
      end
   endtask

   // driver: send pending request bytes, predict on acceptance
   int  send_gap = 0;
   always @(posedge clock) begin
      logic       nv;
      logic [7:0] nd;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      nv = req_valid;
      nd = req_character;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_byte(req_character);
            nv = 1'b0;
            send_gap = (cycles % 4096 < 600) ? 0 : $urandom_range(0, 7);
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (byte_q.size() > 0) begin
               nd = byte_q.pop_front();
               nv = 1'b1;
            end
         end
      end
      req_valid <= nv;
      req_character <= nd;
   end

   // monitor: check responses, drive stall with one long hold-off
   int recv_gap = 0;
   int hold_off = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      fix_result_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            resp_count++;
            if (fix_q.size() == 0) begin
               errors++;
               $display("%0t unexpected response code %0d", $time, rsp_result_code);
            end else begin
               e = fix_q.pop_front();
               check_field("result_code", 64'(e.code), 64'(rsp_result_code));
               check_field("hour", 64'(e.hour), 64'(rsp_hour));
               check_field("minute", 64'(e.minute), 64'(rsp_minute));
               check_field("second", 64'(e.second), 64'(rsp_second));
               check_field("millisecond", 64'(e.msec), 64'(rsp_millisecond));
               check_field("latitude_e7", 64'(e.lat), 64'(rsp_latitude_e7));
               check_field("latitude_hemisphere", 64'(e.lat_h),
                           64'(rsp_latitude_hemisphere));
               check_field("longitude_e7", 64'(e.lon), 64'(rsp_longitude_e7));
               check_field("longitude_hemisphere", 64'(e.lon_h),
                           64'(rsp_longitude_hemisphere));
               check_field("speed_centi", 64'(e.speed), 64'(rsp_speed_centi));
               check_field("course_centi", 64'(e.course), 64'(rsp_course_centi));
               check_field("date_ddmmyy", 64'(e.date), 64'(rsp_date_ddmmyy));
            end
            recv_gap = (cycles % 4096 < 600) ? 0 : $urandom_range(0, 7);
            if (!hold_done && resp_count == 40) begin
               hold_done = 1'b1;
               hold_off = 400;
            end
         end else if (hold_off > 0) begin
            hold_off--;
         end else if (recv_gap > 0) begin
            recv_gap--;
         end
      end
      rsp_stall <= (hold_off > 0) || (recv_gap > 0);
   end

   initial begin
      int wait_cnt;
      hm = 0; fi = 0; dp = 0; err = 0; acc = 0; fr = 0;
      for (int i = 0; i < 4; i++) begin
         pend[i] = 0;
         held[i] = 0;
      end
      // directed sentences
      put_str("$GPRMC,123519.123,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
      put_str("$GPRMC,235959,V,9959.9999,S,17959.9999,W,9999999.99,9999999.99,99999999*00");
      put_str("$GPRMC,,,,,,,,,*00");
      put_str("$GPRMC,010203,X,1,N*00");
      put_str("$GPRMC,010203,A,12345678,Q,1,E*00");
      put_str("$GPRMC,010203,A,1,N,12x45.6,Z*00");
      put_str("$GPRMC,1.2.3,A*");
      put_str("$GPRMC,0102");
      put_str("$GPRMC,111111.9,A,,,,,1.,.5,1a2*");
      byte_q.push_back(8'h00);
      byte_q.push_back(8'hFF);
      put_str("$GPRMzz$GPRMCjunk,22,A,0,S,0,W,0,0,0*");
      // random sentences with noise between them
      while (byte_q.size() < 1900) begin
         if ($urandom_range(0, 7) == 0) put_any($urandom_range(1, 6));
         put_sentence();
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (byte_q.size() == 0);
      @(posedge clock);
      wait (!req_valid && fix_q.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && fix_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
